// ----- src/ihc_pkg.sv -----
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int unsigned HDR_MIN   = 20;
  localparam int unsigned SUM_W     = 20;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_BAD_HLEN  = 3'd3;
  localparam logic [2:0] ST_BAD_TOTAL = 3'd4;

  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] IHL_NO_OPTS  = 4'd5;

  // header state captured over one packet
  typedef struct packed {
    logic [15:0]      len;
    logic [7:0]       vihl;
    logic [15:0]      tot;
    logic [15:0]      fo;
    logic [7:0]       proto;
    logic [15:0]      cks;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [SUM_W-1:0] sum;
  } hdr_t;

endpackage

// ----- src/ihc_capture.sv -----
// ----------------------------------------------------------------------------
// ihc_capture
// Per-byte header field capture and ones'-complement word accumulation.
// ----------------------------------------------------------------------------
module ihc_capture
  import ihc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output hdr_t       hdr_next
);

  localparam logic [4:0] POS_VIHL   = 5'd0;
  localparam logic [4:0] POS_TOT_HI = 5'd2;
  localparam logic [4:0] POS_TOT_LO = 5'd3;
  localparam logic [4:0] POS_FO_HI  = 5'd6;
  localparam logic [4:0] POS_FO_LO  = 5'd7;
  localparam logic [4:0] POS_PROTO  = 5'd9;
  localparam logic [4:0] POS_CKS_HI = 5'd10;
  localparam logic [4:0] POS_CKS_LO = 5'd11;
  localparam logic [4:0] POS_SRC    = 5'd12;
  localparam logic [4:0] POS_DST    = 5'd16;

  hdr_t       hdr;
  logic [7:0] pending;
  logic [7:0] pending_next;
  logic [4:0] pos;
  logic       in_hdr;

  assign pos    = hdr.len[4:0];
  assign in_hdr = (hdr.len < 16'(HDR_MIN));

  always_comb begin
    hdr_next     = hdr;
    pending_next = pending;
    hdr_next.len = (hdr.len == COUNT_MAX) ? hdr.len : hdr.len + 16'd1;
    if (in_hdr) begin
      case (pos)
        POS_VIHL:   hdr_next.vihl  = data_byte;
        POS_TOT_HI: hdr_next.tot   = {data_byte, 8'd0};
        POS_TOT_LO: hdr_next.tot   = {hdr.tot[15:8], data_byte};
        POS_FO_HI:  hdr_next.fo    = {data_byte, 8'd0};
        POS_FO_LO:  hdr_next.fo    = {hdr.fo[15:8], data_byte};
        POS_PROTO:  hdr_next.proto = data_byte;
        POS_CKS_HI: hdr_next.cks   = {data_byte, 8'd0};
        POS_CKS_LO: hdr_next.cks   = {hdr.cks[15:8], data_byte};
        default: ;
      endcase
      if (pos >= POS_SRC && pos < POS_DST)
        hdr_next.src = {hdr.src[23:0], data_byte};
      if (pos >= POS_DST)
        hdr_next.dst = {hdr.dst[23:0], data_byte};
      // even byte opens a word, odd byte closes it; checksum word skipped
      if (!pos[0])
        pending_next = data_byte;
      else if (pos != POS_CKS_LO)
        hdr_next.sum = hdr.sum + SUM_W'({pending, data_byte});
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      hdr     <= '0;
      pending <= '0;
    end else if (step) begin
      hdr     <= hdr_next;
      pending <= pending_next;
    end
  end

endmodule

// ----- src/ipv4_header_checker_core.sv -----
// ----------------------------------------------------------------------------
// ipv4_header_checker_core
// IPv4 header parse and header checksum check, one packet byte per request.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle with no gaps needed between packets. Each
// byte is registered, then folded into the captured header state. On the byte
// marked last, the header state is snapshotted and checked; the check result is
// registered at the output. The per-byte state update (one 20-bit add and
// field capture) sets the one-byte-per-cycle rate. A waiting result
// does not stop input: bytes keep flowing until a last byte finds both the
// snapshot stage and the result register occupied.
module ipv4_header_checker_core
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  version,
  output logic [5:0]  header_bytes,
  output logic        options_present,
  output logic [15:0] total_length,
  output logic        checksum_ok,
  output logic [15:0] flags_offset,
  output logic [7:0]  protocol,
  output logic [31:0] source_address,
  output logic [31:0] dest_address
);

  logic       v0, v1, v2;
  logic       adv0, adv1;
  logic [7:0] byte_q;
  logic       last_q;
  hdr_t       hdr_next;
  hdr_t       snap;

  assign adv1     = v1 && (!v2 || out_ready);
  assign adv0     = v0 && (!last_q || !v1 || adv1);
  assign in_ready = !v0 || adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready)
        v0 <= in_valid;
      if (adv0 && last_q)
        v1 <= 1'b1;
      else if (adv1)
        v1 <= 1'b0;
      if (adv1)
        v2 <= 1'b1;
      else if (out_ready)
        v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
    if (adv0 && last_q)
      snap <= hdr_next;
  end

  ihc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (adv0),
    .data_byte (byte_q),
    .last_byte (last_q),
    .hdr_next  (hdr_next)
  );

  // checks and checksum fold on the snapshot
  logic [3:0]  c_ver, c_ihl;
  logic [5:0]  c_hbytes;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [2:0]  c_status;
  logic        c_short;

  always_comb begin
    c_ver    = snap.vihl[7:4];
    c_ihl    = snap.vihl[3:0];
    c_hbytes = {c_ihl, 2'b00};
    c_short  = (snap.len < 16'(HDR_MIN));
    fold1    = {1'b0, snap.sum[15:0]} + 17'(snap.sum[SUM_W-1:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    if (c_short)
      c_status = ST_SHORT;
    else if (c_ver != IPV4_VERSION)
      c_status = ST_BAD_VER;
    else if (c_hbytes < 6'(HDR_MIN) || 16'(c_hbytes) > snap.len)
      c_status = ST_BAD_HLEN;
    else if (snap.tot < 16'(c_hbytes) || snap.tot > snap.len)
      c_status = ST_BAD_TOTAL;
    else
      c_status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      status          <= c_status;
      version         <= c_short ? '0 : c_ver;
      header_bytes    <= c_short ? '0 : c_hbytes;
      options_present <= !c_short && (c_ihl > IHL_NO_OPTS);
      total_length    <= c_short ? '0 : snap.tot;
      checksum_ok     <= (c_status == ST_OK) && (~fold2 == snap.cks);
      flags_offset    <= (c_status == ST_OK) ? snap.fo : '0;
      protocol        <= c_short ? '0 : snap.proto;
      source_address  <= c_short ? '0 : snap.src;
      dest_address    <= c_short ? '0 : snap.dst;
    end
  end

  assign out_valid = v2;

endmodule

// ----- src/ihc_checker.sv -----
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level assertions for the IPv4 header checker, bound to the top level.
// ----------------------------------------------------------------------------
module ihc_checker
  import ihc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [3:0]  version,
  input logic [5:0]  header_bytes,
  input logic        options_present,
  input logic [15:0] total_length,
  input logic        checksum_ok,
  input logic [15:0] flags_offset,
  input logic [7:0]  protocol,
  input logic [31:0] source_address,
  input logic [31:0] dest_address
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(source_address)
      && $stable(checksum_ok))
    else $error("result changed while stalled");

  a_reject_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !checksum_ok && flags_offset == 16'd0)
    else $error("rejected request carries checksum or fragment fields");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SHORT |-> version == 4'd0 && header_bytes == 6'd0
      && total_length == 16'd0 && protocol == 8'd0 && dest_address == 32'd0)
    else $error("short packet result has nonzero fields");

  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> version == IPV4_VERSION
      && header_bytes >= 6'(HDR_MIN) && total_length >= 16'(header_bytes))
    else $error("accepted result violates header checks");

  a_options: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> options_present == (header_bytes > 6'(HDR_MIN)))
    else $error("options flag disagrees with header length");

endmodule

bind ipv4_header_checker_core ihc_checker u_ihc_checker (.*);
